// ===== rtl/core/fsp_pkg.sv =====
`default_nettype none

package fsp_pkg;

   // Fixed widths of the stream payload fields.
   localparam int BYTE_W    = 8;
   localparam int KIND_W    = 3;
   localparam int VAL_W     = 32;
   localparam int SLOT_W    = 4;
   localparam int MODE_W    = 2;
   localparam int NUM_SLOTS = 16;

   // Characters with a special meaning in the text.
   localparam logic [BYTE_W-1:0] CH_GT       = 8'h3E;
   localparam logic [BYTE_W-1:0] CH_LF       = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_CR       = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_TAB      = 8'h09;
   localparam logic [BYTE_W-1:0] CH_SPACE    = 8'h20;
   localparam logic [BYTE_W-1:0] CH_UPPER_A  = 8'h41;
   localparam logic [BYTE_W-1:0] CH_UPPER_Z  = 8'h5A;
   localparam logic [BYTE_W-1:0] CASE_OFFSET = 8'd32;

   typedef enum logic [MODE_W-1:0] {
      MODE_SEQ,
      MODE_HDR,
      MODE_LEN,
      MODE_COMP
   } mode_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_RESIDUE,
      KIND_HEADER,
      KIND_SEP,
      KIND_LENGTH,
      KIND_RECNUM,
      KIND_COUNT,
      KIND_ERROR
   } kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_COUNTS
   } state_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] slot;
   } slot_type;

   // Map a byte to its composition slot in the order atgcwrmkysbvhdnx, either case.
   function automatic slot_type sym_slot(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] lo;
      slot_type          r;
      lo = ((b >= CH_UPPER_A) && (b <= CH_UPPER_Z)) ? b + CASE_OFFSET : b;
      r.hit  = 1'b1;
      r.slot = '0;
      case (lo)
         "a": r.slot = 4'd0;
         "t": r.slot = 4'd1;
         "g": r.slot = 4'd2;
         "c": r.slot = 4'd3;
         "w": r.slot = 4'd4;
         "r": r.slot = 4'd5;
         "m": r.slot = 4'd6;
         "k": r.slot = 4'd7;
         "y": r.slot = 4'd8;
         "s": r.slot = 4'd9;
         "b": r.slot = 4'd10;
         "v": r.slot = 4'd11;
         "h": r.slot = 4'd12;
         "d": r.slot = 4'd13;
         "n": r.slot = 4'd14;
         "x": r.slot = 4'd15;
         default: r.hit = 1'b0;
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fsp_req_if.sv =====
`default_nettype none

interface fsp_req_if
   import fsp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] stream_byte;
   logic              end_of_input;

   modport source (output valid, output stream_byte, output end_of_input, input ready);
   modport sink   (input valid, input stream_byte, input end_of_input, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fsp_rsp_if.sv =====
`default_nettype none

interface fsp_rsp_if
   import fsp_pkg::*;
();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] result_kind;
   logic [BYTE_W-1:0] char_value;
   logic [VAL_W-1:0]  count_value;
   logic [SLOT_W-1:0] symbol_index;
   logic              last_of_run;

   modport source (output valid, output result_kind, output char_value, output count_value,
                   output symbol_index, output last_of_run, input ready);
   modport sink   (input valid, input result_kind, input char_value, input count_value,
                   input symbol_index, input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fasta_stream_parser_core.sv =====
// Output: each result is registered and is in the output register in the cycle after its input transfer.
// Throughput: one byte per cycle while the output register is free. A record end in
// composition mode holds the input while the symbol counts are read from the count
// memory and put out in slot order; the hold grows while the result channel stalls.
// Reset: synchronous, active high; clears control state and the 16 count valid bits.
// The count memory itself needs no clearing pass.
`default_nettype none

module fasta_stream_parser_core
   import fsp_pkg::*;
#(
   parameter int COUNT_WIDTH = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   fsp_req_if.sink                req_if,
   fsp_rsp_if.source              rsp_if,
   input  wire logic              csr_wr_en,
   input  wire logic [MODE_W-1:0] csr_wr_data
);

   typedef logic [COUNT_WIDTH-1:0] cnt_type;

   localparam cnt_type CNT_MAX = '1;

   function automatic cnt_type sat_inc(input cnt_type v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   // Control and stream state.
   state_type              state_ff, state_in;
   mode_type               mode_ff;
   logic                   in_header_ff, in_header_in;
   logic                   halted_ff, halted_in;
   cnt_type                rec_cnt_ff, rec_cnt_in;
   cnt_type                res_len_ff, res_len_in;
   logic [NUM_SLOTS-1:0]   vld_ff, vld_in;

   // Count memory and its read-modify-write pipeline.
   cnt_type                cnt_mem [NUM_SLOTS];
   logic [SLOT_W-1:0]      rd_addr;
   cnt_type                rd_data_ff;
   logic                   rd_vld_ff;
   logic                   pend_ff, pend_in;
   logic [SLOT_W-1:0]      pend_slot_ff, pend_slot_in;
   logic                   fwd_ok_ff;
   logic [SLOT_W-1:0]      fwd_slot_ff;
   cnt_type                fwd_data_ff;
   logic                   wr_en;
   cnt_type                wr_base;
   cnt_type                wr_data;

   // Composition readout sequencing.
   logic [SLOT_W-1:0]      idx_ff, idx_in;
   logic                   data_ok_ff, data_ok_in;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   kind_type               rsp_kind_ff, rsp_kind_in;
   logic [BYTE_W-1:0]      rsp_char_ff, rsp_char_in;
   logic [VAL_W-1:0]       rsp_count_ff, rsp_count_in;
   logic [SLOT_W-1:0]      rsp_index_ff, rsp_index_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic                   out_load;
   logic                   out_free;

   logic                   acc;
   logic                   is_space;
   logic                   rec_end;
   slot_type               sym;

   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE) && out_free;
   assign acc          = req_if.valid && req_if.ready;
   assign sym          = sym_slot(req_if.stream_byte);
   assign is_space     = (req_if.stream_byte == CH_SPACE) || (req_if.stream_byte == CH_TAB) ||
                         (req_if.stream_byte == CH_CR) || (req_if.stream_byte == CH_LF);
   assign rec_end      = req_if.end_of_input ||
                         (!in_header_ff && (req_if.stream_byte == CH_GT));

   // Write-back stage: the count read last cycle, or the value written last cycle when
   // that write went to the same slot while the read was under way.
   assign wr_en   = pend_ff;
   assign wr_base = (fwd_ok_ff && (fwd_slot_ff == pend_slot_ff)) ? fwd_data_ff :
                    (rd_vld_ff ? rd_data_ff : '0);
   assign wr_data = sat_inc(wr_base);

   // Next state, memory address and output register load.
   always_comb begin
      state_in     = state_ff;
      in_header_in = in_header_ff;
      halted_in    = halted_ff;
      rec_cnt_in   = rec_cnt_ff;
      res_len_in   = res_len_ff;
      vld_in       = vld_ff;
      pend_in      = 1'b0;
      pend_slot_in = pend_slot_ff;
      idx_in       = idx_ff;
      data_ok_in   = data_ok_ff;
      rd_addr      = sym.slot;
      out_load     = 1'b0;
      rsp_kind_in  = KIND_RESIDUE;
      rsp_char_in  = '0;
      rsp_count_in = '0;
      rsp_index_in = '0;
      rsp_last_in  = 1'b1;

      if (wr_en) begin
         vld_in[pend_slot_ff] = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (acc && !halted_ff) begin
               if (rec_end) begin
                  // Report the finished record as the mode asks.
                  if (rec_cnt_ff != '0) begin
                     case (mode_ff)
                        MODE_SEQ: begin
                           out_load    = 1'b1;
                           rsp_kind_in = KIND_SEP;
                        end
                        MODE_LEN: begin
                           out_load     = 1'b1;
                           rsp_kind_in  = KIND_LENGTH;
                           rsp_count_in = VAL_W'(res_len_ff);
                        end
                        MODE_COMP: begin
                           out_load     = 1'b1;
                           rsp_kind_in  = KIND_RECNUM;
                           rsp_count_in = VAL_W'(rec_cnt_ff);
                           rsp_last_in  = 1'b0;
                           state_in     = ST_COUNTS;
                           idx_in       = '0;
                           data_ok_in   = 1'b0;
                        end
                        default: begin
                        end
                     endcase
                  end
                  // Counts are cleared now, or after the readout in composition mode.
                  if (!((rec_cnt_ff != '0) && (mode_ff == MODE_COMP))) begin
                     vld_in = '0;
                  end
                  res_len_in = '0;
                  if (req_if.end_of_input) begin
                     rec_cnt_in   = '0;
                     in_header_in = 1'b0;
                  end else begin
                     rec_cnt_in   = sat_inc(rec_cnt_ff);
                     in_header_in = 1'b1;
                  end
               end else if (in_header_ff) begin
                  // Header text up to and including the line feed.
                  if (mode_ff == MODE_HDR) begin
                     out_load    = 1'b1;
                     rsp_kind_in = KIND_HEADER;
                     rsp_char_in = req_if.stream_byte;
                  end
                  if (req_if.stream_byte == CH_LF) begin
                     in_header_in = 1'b0;
                  end
               end else if (is_space) begin
                  // White space in sequence data is skipped.
               end else if (sym.hit) begin
                  res_len_in   = sat_inc(res_len_ff);
                  pend_in      = 1'b1;
                  pend_slot_in = sym.slot;
                  if (mode_ff == MODE_SEQ) begin
                     out_load    = 1'b1;
                     rsp_kind_in = KIND_RESIDUE;
                     rsp_char_in = req_if.stream_byte;
                  end
               end else if (mode_ff == MODE_SEQ) begin
                  out_load    = 1'b1;
                  rsp_kind_in = KIND_ERROR;
                  rsp_char_in = req_if.stream_byte;
                  halted_in   = 1'b1;
               end
            end
         end
         ST_COUNTS: begin
            // One count per cycle while the result channel is free; a read that overlaps a write is issued again.
            rd_addr    = idx_ff;
            data_ok_in = !wr_en;
            if (data_ok_ff && out_free) begin
               out_load     = 1'b1;
               rsp_kind_in  = KIND_COUNT;
               rsp_count_in = VAL_W'(rd_vld_ff ? rd_data_ff : '0);
               rsp_index_in = idx_ff;
               rsp_last_in  = (idx_ff == SLOT_W'(NUM_SLOTS - 1));
               rd_addr      = idx_ff + 1'b1;
               idx_in       = idx_ff + 1'b1;
               if (idx_ff == SLOT_W'(NUM_SLOTS - 1)) begin
                  state_in = ST_IDLE;
                  vld_in   = '0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = out_load || (rsp_valid_ff && !rsp_if.ready);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_SEQ;
         in_header_ff <= 1'b0;
         halted_ff    <= 1'b0;
         rec_cnt_ff   <= '0;
         res_len_ff   <= '0;
         vld_ff       <= '0;
         pend_ff      <= 1'b0;
         fwd_ok_ff    <= 1'b0;
         data_ok_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_header_ff <= in_header_in;
         halted_ff    <= halted_in;
         rec_cnt_ff   <= rec_cnt_in;
         res_len_ff   <= res_len_in;
         vld_ff       <= vld_in;
         pend_ff      <= pend_in;
         fwd_ok_ff    <= wr_en;
         data_ok_ff   <= data_ok_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            mode_ff <= mode_type'(csr_wr_data);
         end
      end
   end

   // Payload registers of the pipeline and the output.
   always_ff @(posedge clock) begin
      pend_slot_ff <= pend_slot_in;
      idx_ff       <= idx_in;
      fwd_slot_ff  <= pend_slot_ff;
      fwd_data_ff  <= wr_data;
      rd_vld_ff    <= vld_ff[rd_addr];
      if (out_load) begin
         rsp_kind_ff  <= rsp_kind_in;
         rsp_char_ff  <= rsp_char_in;
         rsp_count_ff <= rsp_count_in;
         rsp_index_ff <= rsp_index_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   // Symbol count memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cnt_mem[pend_slot_ff] <= wr_data;
      end
      rd_data_ff <= cnt_mem[rd_addr];
   end

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.result_kind  = rsp_kind_ff;
   assign rsp_if.char_value   = rsp_char_ff;
   assign rsp_if.count_value  = rsp_count_ff;
   assign rsp_if.symbol_index = rsp_index_ff;
   assign rsp_if.last_of_run  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== rtl/core/fsp_checker.sv =====
`default_nettype none

module fsp_checker
   import fsp_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [KIND_W-1:0] rsp_kind,
   input wire logic [SLOT_W-1:0] rsp_index,
   input wire logic              rsp_last
);

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before transfer");

   // Nothing is offered right after reset.
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered after reset");

   // Single results close their run.
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_RESIDUE || rsp_kind == KIND_HEADER ||
                    rsp_kind == KIND_SEP || rsp_kind == KIND_LENGTH ||
                    rsp_kind == KIND_ERROR) |-> rsp_last)
      else $error("single result without last flag");

   // A record number always opens a composition run.
   a_recnum_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_RECNUM |-> !rsp_last)
      else $error("record number marked last");

   // Only the final symbol count closes a composition run.
   a_count_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_COUNT |->
         (rsp_last == (rsp_index == SLOT_W'(NUM_SLOTS - 1))))
      else $error("count last flag does not match slot");

endmodule

bind fasta_stream_parser_core fsp_checker u_fsp_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_kind  (rsp_if.result_kind),
   .rsp_index (rsp_if.symbol_index),
   .rsp_last  (rsp_if.last_of_run)
);

`default_nettype wire

// ===== verif/testbench.sv =====
`default_nettype none

module testbench;
   import fsp_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_REPORTS = 10;

   // Composition slots in report order, one character per slot, slot 0 leftmost.
   localparam logic [8*NUM_SLOTS-1:0] SYMBOL_ORDER = "atgcwrmkysbvhdnx";

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              eoi;
   } stream_item_type;

   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] ch;
      logic [VAL_W-1:0]  cnt;
      logic [SLOT_W-1:0] idx;
      logic              last;
   } result_type;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [MODE_W-1:0] csr_wr_data;

   fsp_req_if req_bus ();
   fsp_rsp_if rsp_bus ();

   fasta_stream_parser_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Bytes waiting to be sent and results waiting to arrive.
   stream_item_type   pending_bytes[$];
   result_type        expected_results[$];

   // Parser state as the block should hold it.
   mode_type          parse_mode;
   logic              parse_in_header;
   logic              parse_halted;
   logic [VAL_W-1:0]  record_total;
   logic [VAL_W-1:0]  residue_total;
   logic [VAL_W-1:0]  symbol_tally [NUM_SLOTS];

   int                mismatch_count = 0;
   int                cycle_count = 0;
   logic              req_taken = 1'b0;
   stream_item_type   next_item;
   int                burst_left = 0;
   int                gap_left = 0;
   int                stall_window = 0;
   logic [15:0]       stall_pattern = 16'hFFFF;
   result_type        seen;
   result_type        wanted;

   // Free-running clock with a period of 10.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [VAL_W-1:0] sat_inc(input logic [VAL_W-1:0] v);
      return (v == {VAL_W{1'b1}}) ? v : v + 1'b1;
   endfunction

   // Composition slot of a byte without regard to case, or -1 for a non-symbol.
   function automatic int symbol_slot(input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] folded;
      folded = (b >= CH_UPPER_A && b <= CH_UPPER_Z) ? b + CASE_OFFSET : b;
      for (int i = 0; i < NUM_SLOTS; i++)
         if (SYMBOL_ORDER[8*(NUM_SLOTS-1-i) +: 8] == folded) return i;
      return -1;
   endfunction

   function automatic logic is_blank(input logic [BYTE_W-1:0] b);
      return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
   endfunction

   task automatic clear_record();
      residue_total = '0;
      for (int i = 0; i < NUM_SLOTS; i++) symbol_tally[i] = '0;
   endtask

   task automatic clear_stream();
      parse_in_header = 1'b0;
      parse_halted    = 1'b0;
      record_total    = '0;
      clear_record();
   endtask

   task automatic add_result(input kind_type k, input logic [BYTE_W-1:0] c,
                             input logic [VAL_W-1:0] v, input logic [SLOT_W-1:0] s);
      result_type r;
      r.kind = k;
      r.ch   = c;
      r.cnt  = v;
      r.idx  = s;
      r.last = 1'b0;
      expected_results.push_back(r);
   endtask

   // Report for the record that is closing, chosen by the mode in force now.
   task automatic close_record();
      if (record_total != 0) begin
         case (parse_mode)
            MODE_SEQ: add_result(KIND_SEP, '0, '0, '0);
            MODE_LEN: add_result(KIND_LENGTH, '0, residue_total, '0);
            MODE_COMP: begin
               add_result(KIND_RECNUM, '0, record_total, '0);
               for (int i = 0; i < NUM_SLOTS; i++)
                  add_result(KIND_COUNT, '0, symbol_tally[i], SLOT_W'(i));
            end
            default: ;
         endcase
      end
   endtask

   // Advance the parser by one accepted byte and queue the results it causes.
   task automatic predict_transfer(input logic [BYTE_W-1:0] b, input logic eoi);
      int         start_size;
      int         slot;
      result_type tail;
      start_size = expected_results.size();
      if (parse_halted) return;
      if (eoi) begin
         close_record();
         clear_stream();
      end else if (parse_in_header) begin
         if (parse_mode == MODE_HDR) add_result(KIND_HEADER, b, '0, '0);
         if (b == CH_LF) parse_in_header = 1'b0;
      end else if (b == CH_GT) begin
         close_record();
         record_total = sat_inc(record_total);
         clear_record();
         parse_in_header = 1'b1;
      end else if (!is_blank(b)) begin
         slot = symbol_slot(b);
         if (slot >= 0) begin
            residue_total      = sat_inc(residue_total);
            symbol_tally[slot] = sat_inc(symbol_tally[slot]);
            if (parse_mode == MODE_SEQ) add_result(KIND_RESIDUE, b, '0, '0);
         end else if (parse_mode == MODE_SEQ) begin
            add_result(KIND_ERROR, b, '0, '0);
            parse_halted = 1'b1;
         end
      end
      // The final result of the transfer carries the last flag.
      if (expected_results.size() > start_size) begin
         tail      = expected_results.pop_back();
         tail.last = 1'b1;
         expected_results.push_back(tail);
      end
   endtask

   task automatic report_mismatch(input string what, input result_type exp,
                                  input result_type act);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s: expected kind %0d char %02h count %0d slot %0d last %0b",
                  $time, what, exp.kind, exp.ch, exp.cnt, exp.idx, exp.last,
                  ", got kind %0d char %02h count %0d slot %0d last %0b",
                  act.kind, act.ch, act.cnt, act.idx, act.last);
   endtask

   // Checker: compare result transfers first, then predict the byte transfer of this edge.
   always @(posedge clock) begin
      req_taken = req_bus.valid && req_bus.ready;
      if (reset) begin
         parse_mode = MODE_SEQ;
         clear_stream();
         expected_results.delete();
      end else begin
         if (csr_wr_en) parse_mode = mode_type'(csr_wr_data);
         if (rsp_bus.valid && rsp_bus.ready) begin
            seen.kind = kind_type'(rsp_bus.result_kind);
            seen.ch   = rsp_bus.char_value;
            seen.cnt  = rsp_bus.count_value;
            seen.idx  = rsp_bus.symbol_index;
            seen.last = rsp_bus.last_of_run;
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing expected", '0, seen);
            end else begin
               wanted = expected_results.pop_front();
               if (seen.kind !== wanted.kind || seen.ch !== wanted.ch ||
                   seen.cnt !== wanted.cnt || seen.idx !== wanted.idx ||
                   seen.last !== wanted.last)
                  report_mismatch("wrong result", wanted, seen);
            end
         end
         if (req_taken) predict_transfer(req_bus.stream_byte, req_bus.end_of_input);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Byte driver: bursts of random length separated by random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            next_item = pending_bytes.pop_front();
            req_bus.stream_byte  <= next_item.data;
            req_bus.end_of_input <= next_item.eoi;
            req_bus.valid        <= 1'b1;
            if (burst_left > 1) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Result ready follows a stall pattern that is redrawn at the end of each stall window.
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (stall_window == 0) begin
            stall_window  = 63;
            stall_pattern = ($urandom_range(0, 2) == 0) ? 16'hFFFF
                                                         : (16'($urandom()) | 16'h0001);
         end else begin
            stall_window--;
         end
         rsp_bus.ready <= stall_pattern[stall_window % 16];
      end
   end

   task automatic queue_byte(input logic [BYTE_W-1:0] b);
      stream_item_type item;
      item.data = b;
      item.eoi  = 1'b0;
      pending_bytes.push_back(item);
   endtask

   task automatic queue_eoi();
      stream_item_type item;
      item.data = BYTE_W'($urandom_range(0, 255));
      item.eoi  = 1'b1;
      pending_bytes.push_back(item);
   endtask

   function automatic logic [BYTE_W-1:0] random_symbol();
      int                pick;
      logic [BYTE_W-1:0] c;
      pick = $urandom_range(0, NUM_SLOTS - 1);
      c    = SYMBOL_ORDER[8*pick +: 8];
      if ($urandom_range(0, 1) == 1) c = c - CASE_OFFSET;
      return c;
   endfunction

   // Any byte, with the two extreme values drawn more often.
   function automatic logic [BYTE_W-1:0] random_byte();
      if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   // A well-formed record: header line of random bytes other than line feed, then lines of residues.
   task automatic queue_record();
      int                hdr_len;
      int                line_count;
      int                line_len;
      logic [BYTE_W-1:0] c;
      queue_byte(CH_GT);
      hdr_len = $urandom_range(0, 8);
      repeat (hdr_len) begin
         c = random_byte();
         if (c == CH_LF) c = CH_GT;
         queue_byte(c);
      end
      queue_byte(CH_LF);
      line_count = $urandom_range(0, 3);
      repeat (line_count) begin
         line_len = $urandom_range(0, 12);
         repeat (line_len) begin
            if ($urandom_range(0, 7) == 0)
               queue_byte(($urandom_range(0, 1) == 1) ? CH_SPACE : CH_TAB);
            else
               queue_byte(random_symbol());
         end
         if ($urandom_range(0, 2) == 0) queue_byte(CH_CR);
         queue_byte(CH_LF);
      end
   endtask

   // A record cut short by the end of the stream, inside the header or the data.
   task automatic queue_broken_record();
      queue_byte(CH_GT);
      repeat ($urandom_range(0, 4)) queue_byte(random_symbol());
      if ($urandom_range(0, 1) == 1) begin
         queue_byte(CH_LF);
         repeat ($urandom_range(1, 6)) queue_byte(random_symbol());
      end
      queue_eoi();
   endtask

   // Wait until every byte is sent and every result is in, then let the block settle.
   task automatic wait_idle();
      while (pending_bytes.size() != 0 || req_bus.valid || expected_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_mode(input mode_type m);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // One random phase under a fixed mode; stray random bytes go before records only outside sequence mode.
   task automatic run_phase(input mode_type m);
      int record_goal;
      write_mode(m);
      record_goal = $urandom_range(2, 4);
      repeat (record_goal) begin
         if ($urandom_range(0, 5) == 0) queue_broken_record();
         if (m != MODE_SEQ && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 6)) queue_byte(random_byte());
         queue_record();
         if ($urandom_range(0, 7) == 0) queue_eoi();
      end
      wait_idle();
   endtask

   initial begin
      logic [BYTE_W-1:0] bad;
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      req_bus.valid        = 1'b0;
      req_bus.stream_byte  = '0;
      req_bus.end_of_input = 1'b0;
      rsp_bus.ready        = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: data before the first header, extreme header bytes, a nested '>',
      // an empty header, and two ends of stream in a row.
      write_mode(MODE_SEQ);
      queue_byte("a");
      queue_byte(CH_TAB);
      queue_byte("T");
      queue_byte(CH_CR);
      queue_byte(CH_LF);
      queue_byte(CH_GT);
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_byte(CH_GT);
      queue_byte(CH_LF);
      queue_byte("g");
      queue_byte("C");
      queue_byte(CH_SPACE);
      queue_byte("x");
      queue_byte("N");
      queue_byte(CH_GT);
      queue_byte(CH_LF);
      queue_eoi();
      queue_eoi();
      wait_idle();

      // Random phases; records may run across a mode change.
      run_phase(MODE_COMP);
      run_phase(MODE_HDR);
      run_phase(MODE_LEN);
      run_phase(MODE_SEQ);
      run_phase(MODE_COMP);
      run_phase(MODE_LEN);
      run_phase(MODE_HDR);
      run_phase(MODE_SEQ);
      run_phase(MODE_COMP);

      // A bad symbol in sequence mode halts the parser for good, so it comes last.
      write_mode(MODE_SEQ);
      queue_record();
      bad = CH_GT;
      while (symbol_slot(bad) >= 0 || bad == CH_GT || is_blank(bad))
         bad = random_byte();
      queue_byte(bad);
      queue_byte(random_symbol());
      queue_byte(CH_GT);
      queue_byte(CH_LF);
      queue_eoi();
      wait_idle();

      repeat (20) @(negedge clock);
      mismatch_count += expected_results.size();
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/core/fsp_pkg.sv
rtl/core/fsp_req_if.sv
rtl/core/fsp_rsp_if.sv
rtl/core/fasta_stream_parser_core.sv
rtl/core/fsp_checker.sv
verif/testbench.sv
